[rtl/pcln_pkg.sv]
// Package for the periodic cell-list nearest search: sizes, command/status codes,
// register indexes, and controller/datapath interface structs. No dependencies.
`default_nettype none
package pcln_pkg;
    // store sizes; address packing relies on powers of two
    localparam int MAX_ATOMS    = 1024;
    localparam int MAX_PER_CELL = 8;
    localparam int GRID_MAX     = 16;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_STORE_FULL = 2'd1;
    localparam logic [1:0] ST_CELL_FULL = 2'd2;

    localparam logic [2:0] REG_GRID_X = 3'd0;
    localparam logic [2:0] REG_GRID_Y = 3'd1;
    localparam logic [2:0] REG_GRID_Z = 3'd2;
    localparam logic [2:0] REG_BOX_X  = 3'd3;
    localparam logic [2:0] REG_BOX_Y  = 3'd4;
    localparam logic [2:0] REG_BOX_Z  = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, compute query cell
        logic clr_step;   // clear one cell count
        logic add_write;  // store atom and member
        logic nb_first;   // reset neighbor walk
        logic nb_next;    // advance to next neighbor cell
        logic cnt_read;   // issue cell count read
        logic mem_read;   // issue member read for current slot
        logic pos_read;   // issue position read
        logic eval;       // distance stage compute
        logic cmp;        // compare and keep best
        logic res_load;   // latch result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       clr_done;
        logic       store_full;
        logic       cell_full;
        logic       nb_last;
        logic       slot_last; // no more members in this cell
    } t_stat;
endpackage
`default_nettype wire

[rtl/pcln_datapath.sv]
// Datapath: registers, atom/member/count memories, binning, distance unit.
// Depends on pcln_pkg.
`default_nettype none
module pcln_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pcln_pkg::t_cmd    i_cmd,
    output pcln_pkg::t_stat        o_stat,
    input  wire logic [55:0]       i_req,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [15:0]       i_cfg_data,
    output logic [12:0]            o_res
);
    import pcln_pkg::*;
    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int GW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam int CW = 3 * GW;
    localparam int NC = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int SW = (MAX_PER_CELL > 1) ? $clog2(MAX_PER_CELL) : 1;
    localparam int KW = $clog2(MAX_PER_CELL + 1);
    localparam int NW = $clog2(MAX_ATOMS + 1);

    // configuration
    logic [4:0]  r_grid [3];
    logic [15:0] r_box [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid[0] <= 5'd4; r_grid[1] <= 5'd4; r_grid[2] <= 5'd4;
            r_box[0] <= 16'd256; r_box[1] <= 16'd256; r_box[2] <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GRID_X: r_grid[0] <= i_cfg_data[4:0];
                REG_GRID_Y: r_grid[1] <= i_cfg_data[4:0];
                REG_GRID_Z: r_grid[2] <= i_cfg_data[4:0];
                REG_BOX_X:  r_box[0] <= i_cfg_data;
                REG_BOX_Y:  r_box[1] <= i_cfg_data;
                REG_BOX_Z:  r_box[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective grid per axis (1..GRID_MAX)
    logic [GW:0] w_g [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_grid[a] == 5'd0) w_g[a] = (GW+1)'(1);
            else if (32'(r_grid[a]) > GRID_MAX) w_g[a] = (GW+1)'(GRID_MAX);
            else w_g[a] = (GW+1)'(r_grid[a]);
        end
    end

    // request capture and binning: floor(p*g)>>16 in [-g, g), wrap by one add
    logic [1:0]        r_cmdc;
    logic signed [16:0] r_q [3];
    logic [GW-1:0]     r_c [3];
    logic signed [23:0] w_prod [3];
    logic signed [7:0]  w_fl [3];
    logic [GW-1:0]      w_bin [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_prod[a] = 24'(signed'(i_req[2 + 17*a +: 17])) * signed'(24'({1'b0, w_g[a]}));
            w_fl[a]   = 8'(w_prod[a] >>> 16);
            if (w_fl[a] < 0) w_bin[a] = GW'(w_fl[a] + 8'(w_g[a]));
            else w_bin[a] = GW'(w_fl[a]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmdc <= i_req[1:0];
            for (int a = 0; a < 3; a++) begin
                r_q[a] <= signed'(i_req[2 + 17*a +: 17]);
                r_c[a] <= w_bin[a];
            end
        end
    end

    // memories
    logic [50:0]     m_pos [MAX_ATOMS];
    logic [AW-1:0]   m_mem [NC * MAX_PER_CELL];
    logic [KW-1:0]   m_cnt [NC];
    logic [NW-1:0]   r_count;
    logic [CW-1:0]   r_clr;
    logic [KW-1:0]   r_cnt_rd;
    logic [AW-1:0]   r_mem_rd;
    logic [50:0]     r_pos_rd;

    // neighbor walk
    logic [1:0]    r_off [3];
    logic [SW:0]   r_slot;
    logic [GW-1:0] w_nc [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic [GW+1:0] t;
            t = (GW+2)'(r_c[a]) + (GW+2)'(r_off[a]) + (GW+2)'(w_g[a]) - (GW+2)'(1);
            if (t >= (GW+2)'(w_g[a])) t = t - (GW+2)'(w_g[a]);
            if (t >= (GW+2)'(w_g[a])) t = t - (GW+2)'(w_g[a]);
            w_nc[a] = GW'(t);
        end
    end
    wire [CW-1:0] w_addr_add = {r_c[0], r_c[1], r_c[2]};
    wire [CW-1:0] w_addr_nb  = {w_nc[0], w_nc[1], w_nc[2]};
    wire [CW-1:0] w_cnt_addr = i_cmd.add_write || (r_cmdc == CMD_ADD) ? w_addr_add : w_addr_nb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.nb_first) begin
            r_off[0] <= 2'd0; r_off[1] <= 2'd0; r_off[2] <= 2'd0;
        end else if (i_cmd.nb_next) begin
            if (r_off[2] != 2'd2) r_off[2] <= r_off[2] + 2'd1;
            else begin
                r_off[2] <= 2'd0;
                if (r_off[1] != 2'd2) r_off[1] <= r_off[1] + 2'd1;
                else begin
                    r_off[1] <= 2'd0;
                    r_off[0] <= r_off[0] + 2'd1;
                end
            end
        end
        if (i_cmd.cnt_read) r_slot <= '0;
        else if (i_cmd.mem_read) r_slot <= r_slot + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) m_cnt[r_clr] <= '0;
        else if (i_cmd.add_write) m_cnt[w_cnt_addr] <= r_cnt_rd + 1'b1;
        if (i_cmd.cnt_read) r_cnt_rd <= m_cnt[w_cnt_addr];
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write)
            m_mem[{w_addr_add, SW'(r_cnt_rd)}] <= AW'(r_count);
        if (i_cmd.mem_read) r_mem_rd <= m_mem[{w_addr_nb, SW'(r_slot)}];
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write) m_pos[AW'(r_count)] <= {r_q[2], r_q[1], r_q[0]};
        if (i_cmd.pos_read) r_pos_rd <= m_pos[r_mem_rd];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cmd.load && i_req[1:0] == CMD_CLEAR) begin
                r_count <= '0;
                r_clr   <= '0;
            end else if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.add_write) r_count <= r_count + 1'b1;
        end
    end

    // distance: stage1 minimum image and scale, stage2 squares, stage3 sum
    logic signed [15:0] r_s [3];
    logic [29:0]        r_sq [3];
    logic [31:0]        w_sum;
    logic [31:0]        r_best;
    logic               r_found;
    logic [AW-1:0]      r_idx, r_ev_idx, r_cmp_idx;
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            for (int a = 0; a < 3; a++) begin
                logic signed [17:0] d;
                logic signed [15:0] dm;
                logic signed [33:0] pr;
                logic signed [17:0] tr;
                d  = 18'(r_q[a]) - 18'(signed'(r_pos_rd[17*a +: 17]));
                dm = 16'(d);
                pr = 34'(dm) * signed'(34'({1'b0, r_box[a]}));
                if (pr < 0) tr = -18'((-pr) >>> 16);
                else tr = 18'(pr >>> 16);
                r_s[a] <= 16'(tr);
            end
            r_ev_idx <= r_mem_rd;
        end
        if (i_cmd.cmp) begin
            for (int a = 0; a < 3; a++) r_sq[a] <= 30'(32'(r_s[a] * r_s[a]));
            r_cmp_idx <= r_ev_idx;
        end
    end
    assign w_sum = 32'(r_sq[0]) + 32'(r_sq[1]) + 32'(r_sq[2]);
    logic r_cmp_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cmp_vld <= 1'b0;
        else r_cmp_vld <= i_cmd.cmp;
        if (i_cmd.load) r_found <= 1'b0;
        else if (r_cmp_vld && (!r_found || w_sum < r_best)) begin
            r_found <= 1'b1;
            r_best  <= w_sum;
            r_idx   <= r_cmp_idx;
        end
    end

    // result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (r_cmdc)
                CMD_ADD: begin
                    if (r_count >= NW'(MAX_ATOMS)) o_res <= {10'd0, 1'b0, ST_STORE_FULL};
                    else if (32'(r_cnt_rd) >= MAX_PER_CELL)
                        o_res <= {10'd0, 1'b0, ST_CELL_FULL};
                    else o_res <= {10'(r_count), 1'b0, ST_OK};
                end
                CMD_QUERY: o_res <= {r_found ? 10'(r_idx) : 10'd0, r_found, ST_OK};
                default: o_res <= '0;
            endcase
        end
    end

    assign o_stat.cmd        = r_cmdc;
    assign o_stat.clr_done   = (r_clr == CW'(NC - 1));
    assign o_stat.store_full = (r_count >= NW'(MAX_ATOMS));
    assign o_stat.cell_full  = (32'(r_cnt_rd) >= MAX_PER_CELL);
    assign o_stat.nb_last    = (r_off[0] == 2'd2) && (r_off[1] == 2'd2) && (r_off[2] == 2'd2);
    assign o_stat.slot_last  = ((SW+1)'(r_slot) >= (SW+1)'(r_cnt_rd));
endmodule
`default_nettype wire

[rtl/pcln_ctrl.sv]
// Controller: sequences clear sweep, add, and the 27-cell query walk.
// Depends on pcln_pkg.
`default_nettype none
module pcln_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_vld,
    output logic                 o_req_rdy,
    output logic                 o_res_vld,
    input  wire logic            i_res_rdy,
    output pcln_pkg::t_cmd       o_cmd,
    input  wire pcln_pkg::t_stat i_stat
);
    import pcln_pkg::*;
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DEC   = 12'b000000000010,
        S_CLR   = 12'b000000000100,
        S_ACNT  = 12'b000000001000,
        S_AWR   = 12'b000000010000,
        S_QCNT  = 12'b000000100000,
        S_QMEM  = 12'b000001000000,
        S_QPOS  = 12'b000010000000,
        S_QEV   = 12'b000100000000,
        S_QCMP  = 12'b001000000000,
        S_DONE  = 12'b010000000000,
        S_INIT  = 12'b100000000000
    } t_state;
    t_state r_st, n_st;
    logic r_res_vld, n_res_vld;
    logic r_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT;
            r_res_vld <= 1'b0;
            r_drain <= 1'b0;
        end else begin
            r_st <= n_st;
            r_res_vld <= n_res_vld;
            r_drain <= (r_st == S_QCMP);
        end
    end

    always_comb begin
        n_st = r_st;
        o_cmd = '0;
        n_res_vld = r_res_vld && !i_res_rdy;
        o_req_rdy = (r_st == S_IDLE) && !r_res_vld;
        case (r_st)
            S_INIT: begin
                // sweep cell counts to zero after reset, no result
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_vld && o_req_rdy) begin
                    o_cmd.load = 1'b1;
                    n_st = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.nb_first = 1'b1;
                case (i_stat.cmd)
                    CMD_CLEAR: n_st = S_CLR;
                    CMD_ADD:   n_st = S_ACNT;
                    CMD_QUERY: n_st = S_QCNT;
                    default:   n_st = S_DONE;
                endcase
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_st = S_DONE;
            end
            S_ACNT: begin
                o_cmd.cnt_read = 1'b1;
                n_st = S_AWR;
            end
            S_AWR: begin
                if (!i_stat.store_full && !i_stat.cell_full) o_cmd.add_write = 1'b1;
                o_cmd.res_load = 1'b1;
                n_res_vld = 1'b1;
                n_st = S_IDLE;
            end
            S_QCNT: begin
                o_cmd.cnt_read = 1'b1;
                n_st = S_QMEM;
            end
            S_QMEM: begin
                if (i_stat.slot_last) begin
                    if (i_stat.nb_last) n_st = S_DONE;
                    else begin
                        o_cmd.nb_next = 1'b1;
                        n_st = S_QCNT;
                    end
                end else begin
                    o_cmd.mem_read = 1'b1;
                    n_st = S_QPOS;
                end
            end
            S_QPOS: begin
                o_cmd.pos_read = 1'b1;
                n_st = S_QEV;
            end
            S_QEV: begin
                o_cmd.eval = 1'b1;
                n_st = S_QCMP;
            end
            S_QCMP: begin
                o_cmd.cmp = 1'b1;
                n_st = S_QMEM;
            end
            S_DONE: begin
                // load the result only once r_drain is clear, so best is final
                if (!r_drain) begin
                    o_cmd.res_load = 1'b1;
                    n_res_vld = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end
    assign o_res_vld = r_res_vld;
endmodule
`default_nettype wire

[rtl/periodic_cell_list_nearest_search.sv]
// Top level of the periodic cell-list nearest search: controller plus datapath.
// Depends on pcln_pkg, pcln_ctrl, pcln_datapath.
//
// One request at a time: s_axis_tready is high only when idle with no result
// waiting, and the next request is taken the cycle after a result is accepted.
// After reset the block sweeps all GRID_MAX^3 cell counts to zero, one a cycle,
// and s_axis_tready stays low until the sweep is done. A clear command repeats
// the same count sweep, and a query walks the 27 cells around and including
// its own cell. A query does a count read and an end-of-cell check for each
// cell, and a member read, position read, distance and compare for each
// member, walking sequentially through the count, member and position memories.
`default_nettype none
module periodic_cell_list_nearest_search (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // pos_x, pos_y, pos_z, pad
    input  wire logic [1:0]  s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // atom_index, pad
    output logic [2:0]       m_axis_tuser,  // status[1:0], found
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import pcln_pkg::*;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic [12:0] w_res;

    pcln_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_req_vld(s_axis_tvalid), .o_req_rdy(s_axis_tready),
        .o_res_vld(m_axis_tvalid), .i_res_rdy(m_axis_tready),
        .o_cmd(w_cmd), .i_stat(w_stat)
    );
    pcln_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat),
        .i_req({s_axis_tdata[53:0], s_axis_tuser}), .i_cfg_we(i_cfg_valid),
        .i_cfg_idx(i_cfg_index), .i_cfg_data, .o_res(w_res)
    );
    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {6'd0, w_res[12:3]};
    assign m_axis_tuser = w_res[2:0];
endmodule
`default_nettype wire

[rtl/pcln_checker.sv]
// Port-level checker for the nearest search, with its bind.
// Depends on pcln_pkg.
`default_nettype none
module pcln_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);
    import pcln_pkg::*;
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result dropped");
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
    a_no_rdy_with_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while result pending");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ST_OK)
        else $error("found with error status");
endmodule
bind periodic_cell_list_nearest_search pcln_checker u_chk (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire
